FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: property violated");
// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

FILE: hw/rtl/itt_pkg.sv
`timescale 1ns / 1ps
package itt_pkg;

	// Default table depth.
	localparam int unsigned ITT_ENTRIES = 16;

	// Command queue depth between front and back; must be a power of two.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Answer for an id that no entry covers.
	localparam logic [31:0] NOBODY_ID = 32'd65534;

	// Operation codes on the op input.
	localparam logic [1:0] OP_ADD     = 2'd0;
	localparam logic [1:0] OP_NS2HOST = 2'd1;
	localparam logic [1:0] OP_HOST2NS = 2'd2;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_WIDE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		MK_ADD       = 3'd0,
		MK_REBASED   = 3'd1,
		MK_IN_TARGET = 3'd2,
		MK_NOBODY    = 3'd3,
		MK_PASS      = 3'd4
	} kind_t;

	// Class the front assigns to each accepted beat.
	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_ADD,
		CLS_FWD,
		CLS_REV,
		CLS_PASS
	} cls_t;

	// Command handed from front to back through the queue.
	typedef struct packed {
		cls_t        cls;
		logic        too_wide;
		logic [31:0] id;
		logic [31:0] ns_base;
		logic [31:0] host_base;
		logic [32:0] ns_end;
		logic [32:0] host_end;
		logic [31:0] delta;
	} cmd_t;

	// One table entry: both ranges as base and exclusive end, plus host minus ns offset.
	typedef struct packed {
		logic [31:0] ns_base;
		logic [31:0] host_base;
		logic [32:0] ns_end;
		logic [32:0] host_end;
		logic [31:0] delta;
	} entry_t;

	typedef struct packed {
		logic valid;
		logic full;
	} qstat_t;

	typedef struct packed {
		logic scanning;
		logic table_write;
	} bkstat_t;

	typedef enum logic {
		BK_IDLE,
		BK_SCAN
	} bk_state_t;

endpackage

FILE: hw/rtl/itt_ram.sv
`timescale 1ns / 1ps
module itt_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/itt_front.sv
`timescale 1ns / 1ps
module itt_front import itt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] id,
	input  logic [31:0] ns_base,
	input  logic [31:0] host_base,
	input  logic [31:0] range_count,
	input  qstat_t      qstat,
	output logic        push,
	output cmd_t        cmd
);

	logic        map_en_q;
	logic [32:0] ns_end;
	logic [32:0] host_end;
	logic        ns_wide;
	logic        host_wide;

	// Map enable register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_en_q <= 1'b0;
		end else if (cfg_we) begin
			map_en_q <= cfg_wdata;
		end
	end

	// A beat is taken whenever the queue has room.
	assign in_ready = !qstat.full;
	assign push     = in_valid && in_ready;

	// Range ends; an end above 2^32 is rejected, an end of exactly 2^32 is fine.
	assign ns_end    = {1'b0, ns_base} + {1'b0, range_count};
	assign host_end  = {1'b0, host_base} + {1'b0, range_count};
	assign ns_wide   = ns_end[32] && (ns_end[31:0] != 32'd0);
	assign host_wide = host_end[32] && (host_end[31:0] != 32'd0);

	// Classify the beat and precompute what the back needs.
	always_comb begin
		cmd.too_wide  = ns_wide || host_wide;
		cmd.id        = id;
		cmd.ns_base   = ns_base;
		cmd.host_base = host_base;
		cmd.ns_end    = ns_end;
		cmd.host_end  = host_end;
		cmd.delta     = host_base - ns_base;
		case (op)
			OP_ADD:     cmd.cls = CLS_ADD;
			OP_NS2HOST: cmd.cls = map_en_q ? CLS_FWD : CLS_PASS;
			OP_HOST2NS: cmd.cls = map_en_q ? CLS_REV : CLS_PASS;
			default:    cmd.cls = CLS_NONE;
		endcase
	end

endmodule

FILE: hw/rtl/itt_queue.sv
`timescale 1ns / 1ps
module itt_queue import itt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  cmd_t   push_cmd,
	input  logic   pop,
	output cmd_t   head,
	output qstat_t stat
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head       = slot_q[rd_ptr_q];
	assign stat.valid = (count_q != '0);
	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));

endmodule

FILE: hw/rtl/itt_back.sv
`timescale 1ns / 1ps
module itt_back import itt_pkg::*; #(
	parameter int unsigned ENTRIES = ITT_ENTRIES,
	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int unsigned CNT_W = $clog2(ENTRIES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      result_id,
	output logic [1:0]       status,
	output logic [2:0]       match_kind,
	output logic [CNT_W-1:0] used,
	output bkstat_t          stat
);

	bk_state_t        state_q, state_d;
	logic [CNT_W-1:0] used_q, used_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [31:0]      v_q;
	logic             fwd_q;
	logic             latch;

	logic             ram_we;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           wr_entry;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t           e;

	logic             out_valid_q;
	logic [31:0]      res_q, res_d;
	status_t          st_q, st_d;
	kind_t            mk_q, mk_d;
	logic             load;
	logic             out_free;

	logic [31:0]      src_lo, dst_lo;
	logic [32:0]      src_hi, dst_hi;
	logic             hit_src, hit_dst;
	logic [31:0]      rebased;
	logic             last;
	logic             table_full;

	// Entry table.
	assign wr_entry = '{
		ns_base:   cmd.ns_base,
		host_base: cmd.host_base,
		ns_end:    cmd.ns_end,
		host_end:  cmd.host_end,
		delta:     cmd.delta
	};

	itt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (used_q[IDX_W-1:0]),
		.wr_data (wr_entry),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign e = entry_t'(ram_rdata);

	// Range tests on the entry that the table delivers this cycle.
	assign src_lo  = fwd_q ? e.ns_base : e.host_base;
	assign src_hi  = fwd_q ? e.ns_end : e.host_end;
	assign dst_lo  = fwd_q ? e.host_base : e.ns_base;
	assign dst_hi  = fwd_q ? e.host_end : e.ns_end;
	assign hit_dst = ({1'b0, v_q} >= {1'b0, dst_lo}) && ({1'b0, v_q} < dst_hi);
	assign hit_src = ({1'b0, v_q} >= {1'b0, src_lo}) && ({1'b0, v_q} < src_hi);
	assign rebased = fwd_q ? (v_q + e.delta) : (v_q - e.delta);

	assign last       = ((CNT_W'(idx_q) + CNT_W'(1)) == used_q);
	assign table_full = (used_q == CNT_W'(ENTRIES));
	assign out_free   = !out_valid_q || out_ready;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			used_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			idx_q   <= idx_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (latch) begin
			v_q   <= cmd.id;
			fwd_q <= (cmd.cls == CLS_FWD);
		end
		if (load) begin
			res_q <= res_d;
			st_q  <= st_d;
			mk_q  <= mk_d;
		end
	end

	// Sequencer: take one command, scan the table one entry a cycle for translations.
	always_comb begin
		state_d   = state_q;
		used_d    = used_q;
		idx_d     = idx_q;
		cmd_pop   = 1'b0;
		latch     = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		load      = 1'b0;
		res_d     = '0;
		st_d      = ST_OK;
		mk_d      = MK_ADD;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					case (cmd.cls)
						CLS_ADD: begin
							load = 1'b1;
							if (table_full) begin
								st_d = ST_FULL;
							end else if (cmd.too_wide) begin
								st_d = ST_WIDE;
							end else begin
								ram_we = 1'b1;
								used_d = used_q + CNT_W'(1);
							end
						end
						CLS_FWD, CLS_REV: begin
							if (used_q == '0) begin
								load  = 1'b1;
								res_d = NOBODY_ID;
								mk_d  = MK_NOBODY;
							end else begin
								latch     = 1'b1;
								ram_re    = 1'b1;
								ram_raddr = '0;
								idx_d     = '0;
								state_d   = BK_SCAN;
							end
						end
						CLS_PASS: begin
							load  = 1'b1;
							res_d = cmd.id;
							mk_d  = MK_PASS;
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			BK_SCAN: begin
				if (hit_dst || hit_src || last) begin
					// Finish only when the output register can take the result.
					if (out_free) begin
						load    = 1'b1;
						state_d = BK_IDLE;
						if (hit_dst) begin
							res_d = v_q;
							mk_d  = MK_IN_TARGET;
						end else if (hit_src) begin
							res_d = rebased;
							mk_d  = MK_REBASED;
						end else begin
							res_d = NOBODY_ID;
							mk_d  = MK_NOBODY;
						end
					end
				end else begin
					ram_re    = 1'b1;
					ram_raddr = idx_q + IDX_W'(1);
					idx_d     = idx_q + IDX_W'(1);
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	assign out_valid        = out_valid_q;
	assign result_id        = res_q;
	assign status           = st_q;
	assign match_kind       = mk_q;
	assign used             = used_q;
	assign stat.scanning    = (state_q == BK_SCAN);
	assign stat.table_write = ram_we;

endmodule

FILE: hw/rtl/id_range_translation_table_top.sv
// Id range translation table.
// Input channel (in_valid/in_ready) carries op, id, ns_base, host_base and
// range_count; each input beat yields exactly one output beat on the result
// channel (out_valid/out_ready) with result_id, status and match_kind, in order.
// cfg_we/cfg_wdata write the map enable bit; write it only while the block is idle.
// An add, a disabled passthrough or an unused op goes through the queue to the
// back end, which registers its answer in the output register. A translation
// reads the table entry by entry and ends at the first entry that covers the id,
// or misses after the last entry in use. Adds and passthroughs run one per cycle
// while out_ready stays high; a translation holds the back end for its scan, since
// the table has one read port and is scanned one entry per cycle in insertion order.
// A two-deep command queue sits between the input side and the scanner, so new
// beats are taken while a result waits on a stalled receiver; a full queue drops
// in_ready. A result waits in the output register until out_ready.
// Reset empties the table, the queue and the output register and disables the map.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module id_range_translation_table_top import itt_pkg::*; #(
	parameter int unsigned ENTRIES = ITT_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] id,
	input  logic [31:0] ns_base,
	input  logic [31:0] host_base,
	input  logic [31:0] range_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_id,
	output logic [1:0]  status,
	output logic [2:0]  match_kind
);

	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

	logic             push;
	cmd_t             push_cmd;
	cmd_t             head;
	qstat_t           qstat;
	logic             cmd_pop;
	logic [CNT_W-1:0] used;
	bkstat_t          bstat;

	// Front: accept and classify.
	itt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.id          (id),
		.ns_base     (ns_base),
		.host_base   (host_base),
		.range_count (range_count),
		.qstat       (qstat),
		.push        (push),
		.cmd         (push_cmd)
	);

	// Command queue.
	itt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (cmd_pop),
		.head     (head),
		.stat     (qstat)
	);

	// Back: table update and lookup.
	itt_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (qstat.valid),
		.cmd        (head),
		.cmd_pop    (cmd_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_id  (result_id),
		.status     (status),
		.match_kind (match_kind),
		.used       (used),
		.stat       (bstat)
	);

	// The back end only takes commands that are really queued.
	`ASSERT_ALWAYS(a_pop_nonempty, clk, arst_n, cmd_pop |-> qstat.valid)
	// An accepted beat is queued by the next cycle.
	`ASSERT_ALWAYS(a_push_lands, clk, arst_n, push |=> qstat.valid)
	// The table is never written while a scan reads it.
	`ASSERT_NEVER(a_no_write_in_scan, clk, arst_n, bstat.scanning && bstat.table_write)
	// The entry count never passes the table depth.
	`ASSERT_NEVER(a_used_bound, clk, arst_n, used > CNT_W'(ENTRIES))

endmodule
